/* rtl/upd_pkg.sv */
// Package for the uplink packet deframer: shared types, codes and the body
// length table. Used by every module of the block; depends on nothing.
package upd_pkg;

  // Widths of the fixed fields.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned NumValues = 4;

  // Queue between the front and the back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Configuration register indexes.
  localparam int unsigned CfgIndexW = 3;
  localparam logic [CfgIndexW-1:0] CFG_HEADER_FIRST  = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_HEADER_SECOND = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_TYPE_COMMAND  = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_TYPE_PARAM    = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_TYPE_MODE     = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_TYPE_WAYPOINT = 3'd5;

  // Packet kinds.
  localparam logic [1:0] KIND_CMD      = 2'd0;
  localparam logic [1:0] KIND_PARAM    = 2'd1;
  localparam logic [1:0] KIND_MODE     = 2'd2;
  localparam logic [1:0] KIND_WAYPOINT = 2'd3;

  // Hunt phases of the front.
  typedef enum logic [1:0] {
    PH_HDR1 = 2'd0,
    PH_HDR2 = 2'd1,
    PH_TYPE = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  // Configuration registers as seen by the front.
  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] type_command;
    logic [ByteW-1:0] type_param;
    logic [ByteW-1:0] type_mode;
    logic [ByteW-1:0] type_waypoint;
  } cfg_t;

  // One classified body byte, handed from front to back.
  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0]       pos;
    logic             last;
    logic [ByteW-1:0] data;
  } beat_t;

  // Handshake between queue and back.
  typedef struct packed {
    logic  valid;
    beat_t beat;
  } queue_out_t;

  // Body length in bytes for each kind.
  function automatic logic [4:0] body_len(input logic [1:0] kind);
    logic [4:0] len;
    case (kind)
      KIND_CMD:      len = 5'd1;
      KIND_PARAM:    len = 5'd5;
      KIND_MODE:     len = 5'd1;
      KIND_WAYPOINT: len = 5'd16;
      default:       len = 5'd1;
    endcase
    return len;
  endfunction

endpackage

/* rtl/uplink_packet_deframer.sv */
// Uplink packet deframer, top level: front, queue and back.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
// Usage:
//   Input channel: one received byte per beat on rx_byte, with in_valid and
//   in_stall. The block hunts for the two header bytes, then a type byte
//   (bytes that match no type are skipped), then collects a body of 1, 5,
//   1 or 16 bytes for command, parameter, mode or waypoint packets.
//   Output channel: one packet per beat with out_valid and out_stall, giving
//   the kind, the code or parameter id and up to four little-endian signed
//   values in thousandths, passed on unscaled. Unused fields read as zero.
//   Configuration: cfg_write with cfg_index (0 to 5) and cfg_data sets the
//   header and type bytes; other indexes are ignored. Write only when idle.
//   Throughput: one byte per cycle while the queue has room; the back retires
//   one queued byte per cycle, but holds a finishing byte while the output stalls.
//   Output path: the last byte of a packet is written into the queue, and the
//   back loads the output register from the queue head as it pops that
//   byte, which waits while a previous packet is held by a stalled receiver.
//   Reset: rst clears the configuration to zero, the hunt, the queue and
//   the output valid flag. When the receiver stalls, the result holds, the
//   back keeps assembling the next packet, and the input stalls only once
//   the four-entry queue is full.
module uplink_packet_deframer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [upd_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [upd_pkg::ByteW-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [upd_pkg::ByteW-1:0]         rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        packet_kind,
  output logic [upd_pkg::ByteW-1:0]         packet_code,
  output logic signed [upd_pkg::ValueW-1:0] value_a,
  output logic signed [upd_pkg::ValueW-1:0] value_b,
  output logic signed [upd_pkg::ValueW-1:0] value_c,
  output logic signed [upd_pkg::ValueW-1:0] value_d
);

  logic                accept;
  logic                push;
  upd_pkg::beat_t      push_beat;
  logic                full;
  upd_pkg::queue_out_t head;
  logic                pop;

  // Input beats are taken whenever the queue has room.
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  upd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .push      (push),
    .push_beat (push_beat)
  );

  upd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .full      (full),
    .head      (head),
    .pop       (pop)
  );

  upd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packet_kind (packet_kind),
    .packet_code (packet_code),
    .value_a     (value_a),
    .value_b     (value_b),
    .value_c     (value_c),
    .value_d     (value_d)
  );

endmodule

/* rtl/upd_front.sv */
// Front of the deframer: configuration registers, header and type hunt,
// and tagging of body bytes. Depends on upd_pkg.
module upd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [upd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [upd_pkg::ByteW-1:0]     cfg_data,
  input  logic                          accept,
  input  logic [upd_pkg::ByteW-1:0]     rx_byte,
  output logic                          push,
  output upd_pkg::beat_t                push_beat
);

  upd_pkg::cfg_t   cfg;
  upd_pkg::phase_t phase;
  upd_pkg::phase_t phase_next;
  logic [1:0]      kind;
  logic [1:0]      kind_next;
  logic [4:0]      remaining;
  logic [4:0]      remaining_next;
  logic            type_hit;
  logic [1:0]      type_kind;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        upd_pkg::CFG_HEADER_FIRST:  cfg.header_first  <= cfg_data;
        upd_pkg::CFG_HEADER_SECOND: cfg.header_second <= cfg_data;
        upd_pkg::CFG_TYPE_COMMAND:  cfg.type_command  <= cfg_data;
        upd_pkg::CFG_TYPE_PARAM:    cfg.type_param    <= cfg_data;
        upd_pkg::CFG_TYPE_MODE:     cfg.type_mode     <= cfg_data;
        upd_pkg::CFG_TYPE_WAYPOINT: cfg.type_waypoint <= cfg_data;
        default: ;
      endcase
    end
  end

  // Type byte match, in priority order command, parameter, mode, waypoint.
  always_comb begin
    type_hit  = 1'b1;
    type_kind = upd_pkg::KIND_CMD;
    if (rx_byte == cfg.type_command) begin
      type_kind = upd_pkg::KIND_CMD;
    end else if (rx_byte == cfg.type_param) begin
      type_kind = upd_pkg::KIND_PARAM;
    end else if (rx_byte == cfg.type_mode) begin
      type_kind = upd_pkg::KIND_MODE;
    end else if (rx_byte == cfg.type_waypoint) begin
      type_kind = upd_pkg::KIND_WAYPOINT;
    end else begin
      type_hit = 1'b0;
    end
  end

  // Next state of the hunt.
  always_comb begin
    phase_next     = phase;
    kind_next      = kind;
    remaining_next = remaining;
    if (accept) begin
      case (phase)
        upd_pkg::PH_HDR1: begin
          if (rx_byte == cfg.header_first) phase_next = upd_pkg::PH_HDR2;
        end
        upd_pkg::PH_HDR2: begin
          phase_next = (rx_byte == cfg.header_second) ? upd_pkg::PH_TYPE
                                                      : upd_pkg::PH_HDR1;
        end
        upd_pkg::PH_TYPE: begin
          if (type_hit) begin
            kind_next      = type_kind;
            remaining_next = upd_pkg::body_len(type_kind);
            phase_next     = upd_pkg::PH_BODY;
          end
        end
        upd_pkg::PH_BODY: begin
          remaining_next = remaining - 5'd1;
          if (remaining == 5'd1) phase_next = upd_pkg::PH_HDR1;
        end
        default: phase_next = upd_pkg::PH_HDR1;
      endcase
    end
  end

  // Body bytes go to the queue with their kind and place in the body.
  always_comb begin
    push           = accept && (phase == upd_pkg::PH_BODY);
    push_beat.kind = kind;
    push_beat.pos  = 4'(upd_pkg::body_len(kind) - remaining);
    push_beat.last = (remaining == 5'd1);
    push_beat.data = rx_byte;
  end

  // Hunt state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= upd_pkg::PH_HDR1;
      kind      <= upd_pkg::KIND_CMD;
      remaining <= '0;
    end else begin
      phase     <= phase_next;
      kind      <= kind_next;
      remaining <= remaining_next;
    end
  end

`ifndef ASSERT_OFF
  // A body in progress always has at least one byte still to come.
  assert property (@(posedge clk) disable iff (rst)
    (phase == upd_pkg::PH_BODY) |-> (remaining != 5'd0))
    else $error("body phase with no bytes remaining");

  // The last body byte returns the hunt to the first header.
  assert property (@(posedge clk) disable iff (rst)
    (push && push_beat.last) |=> (phase == upd_pkg::PH_HDR1))
    else $error("hunt did not restart after last body byte");
`endif

endmodule

/* rtl/upd_queue.sv */
// Short queue of classified body bytes between the front and the back.
// Depends on upd_pkg.
module upd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  upd_pkg::beat_t      push_beat,
  output logic                full,
  output upd_pkg::queue_out_t head,
  input  logic                pop
);

  upd_pkg::beat_t                slots [upd_pkg::QueueDepth];
  logic [upd_pkg::QueuePtrW-1:0] wr_ptr;
  logic [upd_pkg::QueuePtrW-1:0] rd_ptr;
  logic [upd_pkg::QueueCntW-1:0] count;
  logic                          do_push;
  logic                          do_pop;

  assign full       = (count == upd_pkg::QueueCntW'(upd_pkg::QueueDepth));
  assign head.valid = (count != '0);
  assign head.beat  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_beat;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  // The front never pushes into a full queue, since full stalls the input.
  assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

/* rtl/upd_back.sv */
// Back of the deframer: assembles codes and values from body bytes and holds
// the finished packet in the output register. Depends on upd_pkg.
module upd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  upd_pkg::queue_out_t               head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        packet_kind,
  output logic [upd_pkg::ByteW-1:0]         packet_code,
  output logic signed [upd_pkg::ValueW-1:0] value_a,
  output logic signed [upd_pkg::ValueW-1:0] value_b,
  output logic signed [upd_pkg::ValueW-1:0] value_c,
  output logic signed [upd_pkg::ValueW-1:0] value_d
);

  logic [upd_pkg::ValueW-1:0] store      [upd_pkg::NumValues];
  logic [upd_pkg::ValueW-1:0] store_next [upd_pkg::NumValues];
  logic [upd_pkg::ByteW-1:0]  held_code;
  logic [upd_pkg::ByteW-1:0]  held_code_next;
  logic [3:0]                 vpos;
  logic                       is_value;
  logic                       out_free;
  logic                       finish;
  logic                       is_wp;
  logic                       is_param;

  // A beat moves on unless it finishes a packet and the output is occupied.
  assign out_free = !out_valid || !out_stall;
  assign pop      = head.valid && (!head.beat.last || out_free);
  assign finish   = pop && head.beat.last;
  assign is_wp    = (head.beat.kind == upd_pkg::KIND_WAYPOINT);
  assign is_param = (head.beat.kind == upd_pkg::KIND_PARAM);

  // Decode where the byte lands: code register or a byte of a value.
  always_comb begin
    held_code_next = held_code;
    is_value       = 1'b0;
    vpos           = head.beat.pos;
    if (is_param) begin
      if (head.beat.pos == 4'd0) begin
        held_code_next = head.beat.data;
      end else begin
        is_value = 1'b1;
        vpos     = head.beat.pos - 4'd1;
      end
    end else if (is_wp) begin
      is_value = 1'b1;
    end else begin
      held_code_next = head.beat.data;
    end
  end

  // Little-endian value assembly; the first byte of a value clears the rest.
  always_comb begin
    for (int i = 0; i < upd_pkg::NumValues; i++) begin
      store_next[i] = store[i];
    end
    if (is_value) begin
      case (vpos[1:0])
        2'd0: store_next[vpos[3:2]] = {24'd0, head.beat.data};
        2'd1: store_next[vpos[3:2]][15:8]  = head.beat.data;
        2'd2: store_next[vpos[3:2]][23:16] = head.beat.data;
        2'd3: store_next[vpos[3:2]][31:24] = head.beat.data;
        default: ;
      endcase
    end
  end

  // Assembly registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      held_code <= held_code_next;
      for (int i = 0; i < upd_pkg::NumValues; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload, with unused fields forced to zero by kind.
  always_ff @(posedge clk) begin
    if (finish) begin
      packet_kind <= head.beat.kind;
      packet_code <= is_wp ? '0 : held_code_next;
      value_a     <= (is_wp || is_param) ? store_next[0] : '0;
      value_b     <= is_wp ? store_next[1] : '0;
      value_c     <= is_wp ? store_next[2] : '0;
      value_d     <= is_wp ? store_next[3] : '0;
    end
  end

`ifndef ASSERT_OFF
  // A finished packet never overwrites one that the receiver has not taken.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !finish)
    else $error("result overwritten while stalled");
`endif

endmodule
